### sv/salru_pkg.sv
// shared types and constants for the set-associative lru write-back cache
package salru_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // status from the way scanner to the sequencer
  typedef struct packed {
    logic done;
    logic hit;
    logic inv_found;
  } scan_stat_t;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_STORE = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WB_CYCLES    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FETCH_CYCLES = 1'd1;

  // field widths
  localparam int unsigned CFG_W     = 10;
  localparam int unsigned EXTRA_W   = 11;
  localparam int unsigned BUS_OUT_W = 7;
  localparam int unsigned CNT_W     = 48;

  // reset values and limits
  localparam logic [CFG_W-1:0] WB_CYCLES_RST    = 10'd100;
  localparam logic [CFG_W-1:0] FETCH_CYCLES_RST = 10'd100;
  localparam int unsigned BUS_OUT_MAX = 127;

endpackage

### sv/set_assoc_lru_writeback_cache.sv
// top level: sequencer, set memories and result register of the lru write-back cache
//
//   channel  handshake                    payload
//   in       in_valid / in_ready          req_type, address
//   out      out_valid / out_ready        hit, penalty_cycles, bus_traffic, wrote_back,
//                                         hit_count, miss_count, bus_byte_total,
//                                         writeback_count, private_count
//   cfg      cfg_write_en (no wait)       cfg_index, cfg_data
//
// each transaction reads the set row into a register, lets the single tag comparator step
// through the ways one by one, then writes the row back.
// after reset a clearing pass walks every set of the metadata memory with in_ready low.
// a result waits in the output register; the next transaction is taken meanwhile, but
// its row write and counter update wait until the previous result has been taken.
module set_assoc_lru_writeback_cache #(
  parameter int unsigned NUM_SETS   = 64,
  parameter int unsigned WAYS       = 4,
  parameter int unsigned LINE_BYTES = 32,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                req_type,
  input  logic [31:0]                         address,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic [salru_pkg::EXTRA_W-1:0]       penalty_cycles,
  output logic [salru_pkg::BUS_OUT_W-1:0]     bus_traffic,
  output logic                                wrote_back,
  output logic [salru_pkg::CNT_W-1:0]         hit_count,
  output logic [salru_pkg::CNT_W-1:0]         miss_count,
  output logic [salru_pkg::CNT_W-1:0]         bus_byte_total,
  output logic [salru_pkg::CNT_W-1:0]         writeback_count,
  output logic [salru_pkg::CNT_W-1:0]         private_count,
  input  logic                                cfg_write_en,
  input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [salru_pkg::CFG_W-1:0]         cfg_data
);

  localparam int unsigned OFF_BITS = $clog2(LINE_BYTES);
  localparam int unsigned SET_BITS = $clog2(NUM_SETS);
  localparam int unsigned SW       = (NUM_SETS > 1) ? SET_BITS : 1;
  localparam int          TAG_RAW  = int'(ADDR_BITS) - int'(SET_BITS) - int'(OFF_BITS);
  localparam int unsigned TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int unsigned WW       = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned BYTE_W   = $clog2(2 * LINE_BYTES + 1);
  localparam logic [ADDR_BITS-1:0] SET_MASK = ADDR_BITS'(NUM_SETS - 1);
  localparam int unsigned EW = salru_pkg::EXTRA_W;

  salru_pkg::state_t state, state_next;

  // configuration registers
  logic [salru_pkg::CFG_W-1:0] wb_cycles;
  logic [salru_pkg::CFG_W-1:0] fetch_cycles;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_cycles    <= salru_pkg::WB_CYCLES_RST;
      fetch_cycles <= salru_pkg::FETCH_CYCLES_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        salru_pkg::REG_WB_CYCLES:    wb_cycles    <= cfg_data;
        salru_pkg::REG_FETCH_CYCLES: fetch_cycles <= cfg_data;
        default: ;
      endcase
    end
  end

  // address split
  logic [ADDR_BITS-1:0] blk;
  logic [SW-1:0]        in_set;
  logic [TAG_W-1:0]     in_tag;

  assign blk    = address[ADDR_BITS-1:0] >> OFF_BITS;
  assign in_set = SW'(blk & SET_MASK);
  assign in_tag = TAG_W'(blk >> SET_BITS);

  // request held for the duration of the transaction
  logic             req_store;
  logic [SW-1:0]    req_set;
  logic [TAG_W-1:0] req_tag;
  logic             accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_store <= (req_type == salru_pkg::REQ_STORE);
      req_set   <= in_set;
      req_tag   <= in_tag;
    end
  end

  // set memories: tags, and per-way valid, dirty and recency rank
  logic [WAYS-1:0][TAG_W-1:0] tag_mem   [NUM_SETS];
  logic [WAYS-1:0]            valid_mem [NUM_SETS];
  logic [WAYS-1:0]            dirty_mem [NUM_SETS];
  logic [WAYS-1:0][WW-1:0]    rank_mem  [NUM_SETS];

  logic [WAYS-1:0][TAG_W-1:0] tag_row;
  logic [WAYS-1:0]            valid_row;
  logic [WAYS-1:0]            dirty_row;
  logic [WAYS-1:0][WW-1:0]    rank_row;

  logic [WAYS-1:0][TAG_W-1:0] tag_new;
  logic [WAYS-1:0]            valid_new;
  logic [WAYS-1:0]            dirty_new;
  logic [WAYS-1:0][WW-1:0]    rank_new;

  logic          clearing;
  logic          commit;
  logic [SW-1:0] clr_idx;
  logic [SW-1:0] wr_idx;

  assign wr_idx = clearing ? clr_idx : req_set;

  always_ff @(posedge clk) begin
    if (clearing || commit) begin
      valid_mem[wr_idx] <= clearing ? '0 : valid_new;
      dirty_mem[wr_idx] <= clearing ? '0 : dirty_new;
      rank_mem[wr_idx]  <= clearing ? '0 : rank_new;
    end
    if (commit) begin
      tag_mem[req_set] <= tag_new;
    end
    if (accept) begin
      tag_row   <= tag_mem[in_set];
      valid_row <= valid_mem[in_set];
      dirty_row <= dirty_mem[in_set];
      rank_row  <= rank_mem[in_set];
    end
  end

  // clearing pass position
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (clearing) begin
      clr_idx <= SW'(clr_idx + 1'b1);
    end
  end

  // way scanner
  salru_pkg::scan_stat_t scan_stat;
  logic [WW-1:0] hit_way;
  logic [WW-1:0] inv_way;
  logic [WW-1:0] lru_way;

  salru_way_scan #(
    .WAYS  (WAYS),
    .TAG_W (TAG_W),
    .WW    (WW)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .row_tag   (tag_row),
    .row_valid (valid_row),
    .row_rank  (rank_row),
    .req_tag   (req_tag),
    .stat      (scan_stat),
    .hit_way   (hit_way),
    .inv_way   (inv_way),
    .lru_way   (lru_way)
  );

  // victim choice, writeback decision and cost
  logic [WW-1:0]     way;
  logic              wb;
  logic [WW-1:0]     old_rank;
  logic [BYTE_W-1:0] bytes;
  logic [EW-1:0]     extra;

  always_comb begin
    priority if (scan_stat.hit) begin
      way = hit_way;
    end else if (scan_stat.inv_found) begin
      way = inv_way;
    end else begin
      way = lru_way;
    end
    wb       = !scan_stat.hit && valid_row[way] && dirty_row[way];
    old_rank = valid_row[way] ? rank_row[way] : WW'(WAYS - 1);
    if (scan_stat.hit) begin
      bytes = '0;
      extra = '0;
    end else if (wb) begin
      bytes = BYTE_W'(2 * LINE_BYTES);
      extra = EW'(wb_cycles) + EW'(fetch_cycles);
    end else begin
      bytes = BYTE_W'(LINE_BYTES);
      extra = EW'(fetch_cycles);
    end
  end

  // row update: chosen way becomes most recent, younger valid ways age by one
  always_comb begin
    for (int v = 0; v < WAYS; v++) begin
      if (WW'(v) == way) begin
        tag_new[v]   = req_tag;
        valid_new[v] = 1'b1;
        dirty_new[v] = scan_stat.hit ? (dirty_row[v] || req_store) : req_store;
        rank_new[v]  = '0;
      end else begin
        tag_new[v]   = tag_row[v];
        valid_new[v] = valid_row[v];
        dirty_new[v] = dirty_row[v];
        rank_new[v]  = (valid_row[v] && (rank_row[v] < old_rank)) ?
                       WW'(rank_row[v] + 1'b1) : rank_row[v];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= salru_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    clearing   = 1'b0;
    commit     = 1'b0;
    unique case (state)
      salru_pkg::ST_CLEAR: begin
        clearing = 1'b1;
        if (clr_idx == SW'(NUM_SETS - 1)) begin
          state_next = salru_pkg::ST_IDLE;
        end
      end
      salru_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = salru_pkg::ST_SCAN;
        end
      end
      salru_pkg::ST_SCAN: begin
        if (scan_stat.done) begin
          state_next = salru_pkg::ST_UPDATE;
        end
      end
      salru_pkg::ST_UPDATE: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = salru_pkg::ST_IDLE;
        end
      end
      default: state_next = salru_pkg::ST_CLEAR;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit            <= scan_stat.hit;
      penalty_cycles <= extra;
      bus_traffic    <= (32'(bytes) > 32'(salru_pkg::BUS_OUT_MAX)) ?
                        salru_pkg::BUS_OUT_W'(salru_pkg::BUS_OUT_MAX) :
                        salru_pkg::BUS_OUT_W'(bytes);
      wrote_back     <= wb;
    end
  end

  // running counters, updated in step with the result register
  salru_stats #(
    .BYTE_W (BYTE_W)
  ) u_stats (
    .clk             (clk),
    .rst             (rst),
    .commit          (commit),
    .hit             (scan_stat.hit),
    .wrote_back      (wb),
    .bytes           (bytes),
    .hit_count       (hit_count),
    .miss_count      (miss_count),
    .bus_byte_total  (bus_byte_total),
    .writeback_count (writeback_count),
    .private_count   (private_count)
  );

endmodule

### sv/salru_way_scan.sv
// shared tag comparator stepping through the ways of one set, one way a cycle
module salru_way_scan #(
  parameter int unsigned WAYS  = 4,
  parameter int unsigned TAG_W = 21,
  parameter int unsigned WW    = 2
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [WAYS-1:0][TAG_W-1:0]  row_tag,
  input  logic [WAYS-1:0]             row_valid,
  input  logic [WAYS-1:0][WW-1:0]     row_rank,
  input  logic [TAG_W-1:0]            req_tag,
  output salru_pkg::scan_stat_t       stat,
  output logic [WW-1:0]               hit_way,
  output logic [WW-1:0]               inv_way,
  output logic [WW-1:0]               lru_way
);

  logic          busy;
  logic [WW-1:0] way_idx;
  logic          hit;
  logic          inv_found;
  logic [WW-1:0] best_rank;
  logic          last;
  logic          tag_match;

  assign last      = (way_idx == WW'(WAYS - 1));
  assign tag_match = row_valid[way_idx] && (row_tag[way_idx] == req_tag);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      way_idx <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      way_idx <= '0;
    end else if (busy) begin
      if (last) begin
        busy <= 1'b0;
      end
      way_idx <= WW'(way_idx + 1'b1);
    end
  end

  // trackers: first matching way, first invalid way, first oldest way
  always_ff @(posedge clk) begin
    if (start) begin
      hit       <= 1'b0;
      inv_found <= 1'b0;
      best_rank <= '0;
      hit_way   <= '0;
      inv_way   <= '0;
      lru_way   <= '0;
    end else if (busy) begin
      if (!hit && tag_match) begin
        hit     <= 1'b1;
        hit_way <= way_idx;
      end
      if (!inv_found && !row_valid[way_idx]) begin
        inv_found <= 1'b1;
        inv_way   <= way_idx;
      end
      if ((way_idx == '0) || (row_rank[way_idx] > best_rank)) begin
        best_rank <= row_rank[way_idx];
        lru_way   <= way_idx;
      end
    end
  end

  assign stat.done      = busy && last;
  assign stat.hit       = hit;
  assign stat.inv_found = inv_found;

endmodule

### sv/salru_stats.sv
// saturating running counters for hits, misses, bus bytes, writebacks and private accesses
module salru_stats #(
  parameter int unsigned BYTE_W = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         commit,
  input  logic                         hit,
  input  logic                         wrote_back,
  input  logic [BYTE_W-1:0]            bytes,
  output logic [salru_pkg::CNT_W-1:0]  hit_count,
  output logic [salru_pkg::CNT_W-1:0]  miss_count,
  output logic [salru_pkg::CNT_W-1:0]  bus_byte_total,
  output logic [salru_pkg::CNT_W-1:0]  writeback_count,
  output logic [salru_pkg::CNT_W-1:0]  private_count
);

  localparam int unsigned CW = salru_pkg::CNT_W;

  // add with clamp at all ones
  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
  endfunction

  // counters move once per completed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count       <= '0;
      miss_count      <= '0;
      bus_byte_total  <= '0;
      writeback_count <= '0;
      private_count   <= '0;
    end else if (commit) begin
      private_count <= sat_add(private_count, CW'(1));
      if (hit) begin
        hit_count <= sat_add(hit_count, CW'(1));
      end else begin
        miss_count     <= sat_add(miss_count, CW'(1));
        bus_byte_total <= sat_add(bus_byte_total, CW'(bytes));
      end
      if (wrote_back) begin
        writeback_count <= sat_add(writeback_count, CW'(1));
      end
    end
  end

endmodule
